// ===== rtl/tec_pkg.sv =====
// Shared types, codes and constants of the texture environment combiner.
`timescale 1ns / 1ps

package tec_pkg;

    // Channel slots in a packed ARGB word
    localparam int CH_A = 0;
    localparam int CH_R = 1;
    localparam int CH_G = 2;
    localparam int CH_B = 3;
    localparam int NUM_CH = 4;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEX_HAS_ALPHA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_COLOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMB_COLOR_OP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMB_ALPHA_OP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ARG      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ARG     = 3'd6;

    // Environment modes; 6 and 7 pass the texel through
    localparam logic [2:0] MODE_REPLACE  = 3'd0;
    localparam logic [2:0] MODE_MODULATE = 3'd1;
    localparam logic [2:0] MODE_DECAL    = 3'd2;
    localparam logic [2:0] MODE_ADD      = 3'd3;
    localparam logic [2:0] MODE_BLEND    = 3'd4;
    localparam logic [2:0] MODE_COMBINE  = 3'd5;

    // Combine argument sources; code 3 gives zero
    localparam logic [1:0] SRC_TEXTURE  = 2'd0;
    localparam logic [1:0] SRC_PRIMARY  = 2'd1;
    localparam logic [1:0] SRC_CONSTANT = 2'd2;

    // Combine colour operands; code 3 acts as the plain value
    localparam logic [1:0] COP_VALUE  = 2'd0;
    localparam logic [1:0] COP_INVERT = 2'd1;
    localparam logic [1:0] COP_ALPHA  = 2'd2;

    // Combine functions; code 3 keeps the texel
    localparam logic [1:0] OP_REPLACE  = 2'd0;
    localparam logic [1:0] OP_MODULATE = 2'd1;
    localparam logic [1:0] OP_ADD      = 2'd2;

    // Rounding bias of the divide-by-255 approximation
    localparam logic [16:0] MUL_BIAS = 17'd127;
    // Rounding bias of the 16-to-8 conversion
    localparam logic [16:0] CONV_BIAS = 17'd128;
    localparam logic [7:0]  CH_MAX = 8'd255;

    typedef logic [NUM_CH-1:0][7:0] t_argb;

    typedef struct packed {
        logic [2:0]  env_mode;
        logic        texture_has_alpha;
        logic [31:0] constant_color;
        logic [1:0]  combine_color_op;
        logic [1:0]  combine_alpha_op;
        logic [6:0]  first_arg_setup;
        logic [6:0]  second_arg_setup;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        env_mode:          MODE_MODULATE,
        texture_has_alpha: 1'b1,
        constant_color:    32'd0,
        combine_color_op:  OP_MODULATE,
        combine_alpha_op:  OP_MODULATE,
        first_arg_setup:   7'd0,
        second_arg_setup:  7'd1
    };

    // Per-channel recipe: result = x0 or mul(x0,y0), optionally
    // saturating-added to x1 or mul(x1,y1).
    typedef struct packed {
        logic [7:0] x0;
        logic [7:0] y0;
        logic [7:0] x1;
        logic [7:0] y1;
        logic       mul0;
        logic       mul1;
        logic       sum;
    } t_lane_op;

    // Load enables of the lane pipeline registers
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

// ===== rtl/tec_in_if.sv =====
// Fragment input channel: primary colour and texel with valid/ready.
`timescale 1ns / 1ps

interface tec_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] primary_a;
    logic [15:0] primary_r;
    logic [15:0] primary_g;
    logic [15:0] primary_b;
    logic [7:0]  texel_a;
    logic [7:0]  texel_r;
    logic [7:0]  texel_g;
    logic [7:0]  texel_b;

    modport source (
        output valid, primary_a, primary_r, primary_g, primary_b,
               texel_a, texel_r, texel_g, texel_b,
        input  ready
    );
    modport sink (
        input  valid, primary_a, primary_r, primary_g, primary_b,
               texel_a, texel_r, texel_g, texel_b,
        output ready
    );
endinterface

// ===== rtl/tec_out_if.sv =====
// Combined fragment output channel with valid/ready.
`timescale 1ns / 1ps

interface tec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_a;
    logic [7:0] out_r;
    logic [7:0] out_g;
    logic [7:0] out_b;

    modport source (
        output valid, out_a, out_r, out_g, out_b,
        input  ready
    );
    modport sink (
        input  valid, out_a, out_r, out_g, out_b,
        output ready
    );
endinterface

// ===== rtl/texture_env_combiner_unit.sv =====
// Top level of the texture environment combiner pipeline.
`timescale 1ns / 1ps
//
// Texture environment combiner, one fragment per clock unless stalled.
// i_frag carries the primary colour (16-bit fixed point per channel) and the
// 8-bit ARGB texel; o_frag returns the combined 8-bit ARGB fragment. Both
// are valid/ready channels; a transfer happens when valid and ready are high.
// The configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data, one register per cycle; the user must write them only while
// no fragment is in flight, as the block itself does not enforce this.
// The pipeline has four register stages (operand select, multiply, rounding,
// add). Throughput: one fragment per cycle while the receiver takes results,
// set by the four-stage pipeline; each lane holds two 8x8 multipliers.
// Reset clears all stage valid bits and loads the register defaults
// (modulate, RGBA texture, combine modulating texture by primary).
// When the receiver stalls, each stage holds its item; bubbles ahead of a
// stalled stage still fill, and i_frag.ready drops only once every stage
// holds an item.

module texture_env_combiner_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tec_in_if.sink                           i_frag,
    tec_out_if.source                        o_frag,
    input  logic                             i_cfg_we,
    input  logic [tec_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tec_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    // Configuration registers
    tec_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= tec_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tec_pkg::CFG_ENV_MODE:       r_cfg.env_mode          <= i_cfg_data[2:0];
                tec_pkg::CFG_TEX_HAS_ALPHA:  r_cfg.texture_has_alpha <= i_cfg_data[0];
                tec_pkg::CFG_CONSTANT_COLOR: r_cfg.constant_color    <= i_cfg_data[31:0];
                tec_pkg::CFG_COMB_COLOR_OP:  r_cfg.combine_color_op  <= i_cfg_data[1:0];
                tec_pkg::CFG_COMB_ALPHA_OP:  r_cfg.combine_alpha_op  <= i_cfg_data[1:0];
                tec_pkg::CFG_FIRST_ARG:      r_cfg.first_arg_setup   <= i_cfg_data[6:0];
                tec_pkg::CFG_SECOND_ARG:     r_cfg.second_arg_setup  <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when the next one moves
    logic              en1;
    tec_pkg::t_stage_en stage_en;
    logic              r_vld1;
    logic              r_vld2;
    logic              r_vld3;
    logic              r_vld4;

    assign stage_en.s4 = !r_vld4 || o_frag.ready;
    assign stage_en.s3 = !r_vld3 || stage_en.s4;
    assign stage_en.s2 = !r_vld2 || stage_en.s3;
    assign en1         = !r_vld1 || stage_en.s2;

    assign i_frag.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (en1)         r_vld1 <= i_frag.valid;
            if (stage_en.s2) r_vld2 <= r_vld1;
            if (stage_en.s3) r_vld3 <= r_vld2;
            if (stage_en.s4) r_vld4 <= r_vld3;
        end
    end

    // Stage 1: operand selection
    logic [tec_pkg::NUM_CH-1:0][15:0]        prim;
    tec_pkg::t_argb                          tex;
    tec_pkg::t_lane_op [tec_pkg::NUM_CH-1:0] n_ops;
    tec_pkg::t_lane_op [tec_pkg::NUM_CH-1:0] r_ops;

    assign prim[tec_pkg::CH_A] = i_frag.primary_a;
    assign prim[tec_pkg::CH_R] = i_frag.primary_r;
    assign prim[tec_pkg::CH_G] = i_frag.primary_g;
    assign prim[tec_pkg::CH_B] = i_frag.primary_b;
    assign tex[tec_pkg::CH_A]  = i_frag.texel_a;
    assign tex[tec_pkg::CH_R]  = i_frag.texel_r;
    assign tex[tec_pkg::CH_G]  = i_frag.texel_g;
    assign tex[tec_pkg::CH_B]  = i_frag.texel_b;

    tec_arg_select u_arg_select (
        .i_cfg  (r_cfg),
        .i_prim (prim),
        .i_tex  (tex),
        .o_ops  (n_ops)
    );

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_ops <= n_ops;
        end
    end

    // Stages 2 to 4: one lane per channel
    tec_pkg::t_argb lane_res;

    for (genvar g = 0; g < tec_pkg::NUM_CH; g++) begin : g_lane
        tec_lane u_lane (
            .i_clk (i_clk),
            .i_en  (stage_en),
            .i_op  (r_ops[g]),
            .o_res (lane_res[g])
        );
    end

    assign o_frag.valid = r_vld4;
    assign o_frag.out_a = lane_res[tec_pkg::CH_A];
    assign o_frag.out_r = lane_res[tec_pkg::CH_R];
    assign o_frag.out_g = lane_res[tec_pkg::CH_G];
    assign o_frag.out_b = lane_res[tec_pkg::CH_B];

endmodule

// ===== rtl/tec_arg_select.sv =====
// Front stage logic: primary conversion and per-channel operand selection.
`timescale 1ns / 1ps

module tec_arg_select (
    input  tec_pkg::t_cfg                        i_cfg,
    input  logic [tec_pkg::NUM_CH-1:0][15:0]     i_prim,
    input  tec_pkg::t_argb                       i_tex,
    output tec_pkg::t_lane_op [tec_pkg::NUM_CH-1:0] o_ops
);

    // Round 16-bit fixed point to 8 bits, saturating
    function automatic logic [7:0] conv16(input logic [15:0] x);
        logic [16:0] s;
        begin
            s = {1'b0, x} + tec_pkg::CONV_BIAS;
            conv16 = s[16] ? tec_pkg::CH_MAX : s[15:8];
        end
    endfunction

    function automatic tec_pkg::t_argb pick_source(
        input logic [1:0]     sel,
        input tec_pkg::t_argb tex,
        input tec_pkg::t_argb prim,
        input tec_pkg::t_argb cst
    );
        begin
            case (sel)
                tec_pkg::SRC_TEXTURE:  pick_source = tex;
                tec_pkg::SRC_PRIMARY:  pick_source = prim;
                tec_pkg::SRC_CONSTANT: pick_source = cst;
                default:               pick_source = '0;
            endcase
        end
    endfunction

    function automatic tec_pkg::t_argb make_arg(
        input logic [6:0]     setup,
        input tec_pkg::t_argb tex,
        input tec_pkg::t_argb prim,
        input tec_pkg::t_argb cst
    );
        tec_pkg::t_argb csrc;
        tec_pkg::t_argb asrc;
        tec_pkg::t_argb res;
        begin
            csrc = pick_source(setup[1:0], tex, prim, cst);
            asrc = pick_source(setup[3:2], tex, prim, cst);
            for (int c = tec_pkg::CH_R; c <= tec_pkg::CH_B; c++) begin
                case (setup[5:4])
                    tec_pkg::COP_INVERT: res[c] = ~csrc[c];
                    tec_pkg::COP_ALPHA:  res[c] = csrc[tec_pkg::CH_A];
                    default:             res[c] = csrc[c];
                endcase
            end
            res[tec_pkg::CH_A] = setup[6] ? ~asrc[tec_pkg::CH_A] : asrc[tec_pkg::CH_A];
            make_arg = res;
        end
    endfunction

    // Recipe for one combine function on one channel
    function automatic tec_pkg::t_lane_op comb_op(
        input logic [1:0] op,
        input logic [7:0] x,
        input logic [7:0] y,
        input logic [7:0] keep
    );
        tec_pkg::t_lane_op r;
        begin
            r = '0;
            case (op)
                tec_pkg::OP_REPLACE: r.x0 = x;
                tec_pkg::OP_MODULATE: begin
                    r.x0   = x;
                    r.y0   = y;
                    r.mul0 = 1'b1;
                end
                tec_pkg::OP_ADD: begin
                    r.x0  = x;
                    r.x1  = y;
                    r.sum = 1'b1;
                end
                default: r.x0 = keep;
            endcase
            comb_op = r;
        end
    endfunction

    tec_pkg::t_argb prim8;
    tec_pkg::t_argb cst;
    tec_pkg::t_argb arg0;
    tec_pkg::t_argb arg1;

    // Primary colour to 8 bits, constant colour unpacked
    always_comb begin
        for (int c = 0; c < tec_pkg::NUM_CH; c++) begin
            prim8[c] = conv16(i_prim[c]);
        end
        cst[tec_pkg::CH_A] = i_cfg.constant_color[31:24];
        cst[tec_pkg::CH_R] = i_cfg.constant_color[23:16];
        cst[tec_pkg::CH_G] = i_cfg.constant_color[15:8];
        cst[tec_pkg::CH_B] = i_cfg.constant_color[7:0];
        arg0 = make_arg(i_cfg.first_arg_setup, i_tex, prim8, cst);
        arg1 = make_arg(i_cfg.second_arg_setup, i_tex, prim8, cst);
    end

    // Mode decode into per-channel recipes
    always_comb begin
        for (int c = 0; c < tec_pkg::NUM_CH; c++) begin
            o_ops[c]    = '0;
            o_ops[c].x0 = i_tex[c];
        end
        case (i_cfg.env_mode)
            tec_pkg::MODE_REPLACE: begin
                o_ops[tec_pkg::CH_A].x0 = i_cfg.texture_has_alpha ?
                    i_tex[tec_pkg::CH_A] : prim8[tec_pkg::CH_A];
            end
            tec_pkg::MODE_MODULATE: begin
                for (int c = 0; c < tec_pkg::NUM_CH; c++) begin
                    o_ops[c].x0   = prim8[c];
                    o_ops[c].y0   = i_tex[c];
                    o_ops[c].mul0 = 1'b1;
                end
            end
            tec_pkg::MODE_DECAL: begin
                for (int c = tec_pkg::CH_R; c <= tec_pkg::CH_B; c++) begin
                    o_ops[c].x0   = prim8[c];
                    o_ops[c].y0   = ~i_tex[tec_pkg::CH_A];
                    o_ops[c].mul0 = 1'b1;
                    o_ops[c].x1   = i_tex[c];
                    o_ops[c].y1   = i_tex[tec_pkg::CH_A];
                    o_ops[c].mul1 = 1'b1;
                    o_ops[c].sum  = 1'b1;
                end
                o_ops[tec_pkg::CH_A].x0 = prim8[tec_pkg::CH_A];
            end
            tec_pkg::MODE_ADD: begin
                for (int c = tec_pkg::CH_R; c <= tec_pkg::CH_B; c++) begin
                    o_ops[c].x0  = prim8[c];
                    o_ops[c].x1  = i_tex[c];
                    o_ops[c].sum = 1'b1;
                end
                o_ops[tec_pkg::CH_A].x0   = prim8[tec_pkg::CH_A];
                o_ops[tec_pkg::CH_A].y0   = i_tex[tec_pkg::CH_A];
                o_ops[tec_pkg::CH_A].mul0 = 1'b1;
            end
            tec_pkg::MODE_BLEND: begin
                for (int c = tec_pkg::CH_R; c <= tec_pkg::CH_B; c++) begin
                    o_ops[c].x0   = prim8[c];
                    o_ops[c].y0   = ~i_tex[c];
                    o_ops[c].mul0 = 1'b1;
                    o_ops[c].x1   = cst[c];
                    o_ops[c].y1   = i_tex[c];
                    o_ops[c].mul1 = 1'b1;
                    o_ops[c].sum  = 1'b1;
                end
                o_ops[tec_pkg::CH_A].x0   = prim8[tec_pkg::CH_A];
                o_ops[tec_pkg::CH_A].y0   = i_tex[tec_pkg::CH_A];
                o_ops[tec_pkg::CH_A].mul0 = 1'b1;
            end
            tec_pkg::MODE_COMBINE: begin
                for (int c = tec_pkg::CH_R; c <= tec_pkg::CH_B; c++) begin
                    o_ops[c] = comb_op(i_cfg.combine_color_op, arg0[c], arg1[c], i_tex[c]);
                end
                o_ops[tec_pkg::CH_A] = comb_op(i_cfg.combine_alpha_op,
                    arg0[tec_pkg::CH_A], arg1[tec_pkg::CH_A], i_tex[tec_pkg::CH_A]);
            end
            default: begin
                // reserved mode: texel passes through (set above)
            end
        endcase
    end

endmodule

// ===== rtl/tec_lane.sv =====
// One channel datapath: multiply, round by 255, select term, saturating add.
`timescale 1ns / 1ps

module tec_lane (
    input  logic              i_clk,
    input  tec_pkg::t_stage_en i_en,
    input  tec_pkg::t_lane_op i_op,
    output logic [7:0]        o_res
);

    // Stage 2: raw products
    logic [15:0] r_p0;
    logic [15:0] r_p1;
    logic [7:0]  r_x0_s2;
    logic [7:0]  r_x1_s2;
    logic        r_mul0_s2;
    logic        r_mul1_s2;
    logic        r_sum_s2;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_p0      <= i_op.x0 * i_op.y0;
            r_p1      <= i_op.x1 * i_op.y1;
            r_x0_s2   <= i_op.x0;
            r_x1_s2   <= i_op.x1;
            r_mul0_s2 <= i_op.mul0;
            r_mul1_s2 <= i_op.mul1;
            r_sum_s2  <= i_op.sum;
        end
    end

    // Stage 3: (p + p/256 + 127) / 256, then pick product or plain value
    logic [16:0] n_q0;
    logic [16:0] n_q1;
    logic [7:0]  r_t0;
    logic [7:0]  r_t1;
    logic        r_sum_s3;

    assign n_q0 = {1'b0, r_p0} + {9'd0, r_p0[15:8]} + tec_pkg::MUL_BIAS;
    assign n_q1 = {1'b0, r_p1} + {9'd0, r_p1[15:8]} + tec_pkg::MUL_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_t0     <= r_mul0_s2 ? n_q0[15:8] : r_x0_s2;
            r_t1     <= r_mul1_s2 ? n_q1[15:8] : r_x1_s2;
            r_sum_s3 <= r_sum_s2;
        end
    end

    // Stage 4: saturating add, or the first term alone, into the output register
    logic [8:0] n_s;
    logic [7:0] r_res;

    assign n_s = {1'b0, r_t0} + {1'b0, r_t1};

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            if (r_sum_s3) begin
                r_res <= n_s[8] ? tec_pkg::CH_MAX : n_s[7:0];
            end else begin
                r_res <= r_t0;
            end
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/tec_checker.sv =====
// Port-level assertions of the combiner, bound to the top level.
`timescale 1ns / 1ps

module tec_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data
);

    // A stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result dropped or changed");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // A ready receiver never back-pressures the input
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output ready");

    // With the receiver ready, a transfer in reaches the output once it has moved through the stage registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind texture_env_combiner_unit tec_checker u_tec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_frag.valid),
    .i_in_ready  (i_frag.ready),
    .i_out_valid (o_frag.valid),
    .i_out_ready (o_frag.ready),
    .i_out_data  ({o_frag.out_a, o_frag.out_r, o_frag.out_g, o_frag.out_b})
);
